// ===== hdl/rbam_pkg.sv =====
// ----------------------------------------------------------------------------
// rbam_pkg
// Shared types and constants for the RGB blend mode and alpha mixer.
// ----------------------------------------------------------------------------
package rbam_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned NumChan      = 3;
  localparam int unsigned ModeW        = 3;
  localparam int unsigned WeightW      = 9;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 9;
  localparam int unsigned FifoDepthDef = 4;

  localparam logic [ChanW-1:0]   OverlaySplit = 8'd128;
  localparam logic [ChanW-1:0]   ChanMax      = 8'd255;
  localparam logic [WeightW-1:0] Q8One        = 9'd256;
  // floor(s/3) == (s*683)>>11 for every sum of three 8-bit channels
  localparam logic [9:0]         BrightMul    = 10'd683;
  localparam int unsigned        BrightShift  = 11;

  localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT = 2'd1;

  typedef enum logic [ModeW-1:0] {
    MODE_NORMAL   = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_DARKEN   = 3'd4,
    MODE_LIGHTEN  = 3'd5,
    MODE_DIFF     = 3'd6,
    MODE_ADD      = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    OP_FORE   = 3'd0,
    OP_BACK   = 3'd1,
    OP_MUL    = 3'd2,
    OP_SCREEN = 3'd3,
    OP_DIFF   = 3'd4,
    OP_ADD    = 3'd5
  } ch_op_e;

  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;

  typedef struct packed {
    pixel_t                   back;
    pixel_t                   fore;
    ch_op_e [NumChan-1:0]     op;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hdl/rbam_front.sv =====
// ----------------------------------------------------------------------------
// rbam_front
// Accepts a pixel pair and classifies the per-channel operation.
// ----------------------------------------------------------------------------
module rbam_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rbam_pkg::mode_e  mode_i,
  input  logic             push,
  output logic             full,
  input  rbam_pkg::pixel_t back_i,
  input  rbam_pkg::pixel_t fore_i,
  input  logic             fifo_full_i,
  output logic             item_valid_o,
  output rbam_pkg::item_t  item_o
);
  import rbam_pkg::*;

  logic                 valid_q, valid_d;
  item_t                item_q;
  item_t                item_d;
  logic [9:0]           sum_b, sum_f;
  logic [19:0]          prod_b, prod_f;
  logic [ChanW-1:0]     bright_b, bright_f;
  logic                 back_le;
  logic                 accept;
  logic                 drain;

  assign drain  = valid_q && !fifo_full_i;
  assign full   = valid_q && fifo_full_i;
  assign accept = push && !full;

  always_comb begin
    sum_b    = 10'(back_i[0]) + 10'(back_i[1]) + 10'(back_i[2]);
    sum_f    = 10'(fore_i[0]) + 10'(fore_i[1]) + 10'(fore_i[2]);
    prod_b   = sum_b * BrightMul;
    prod_f   = sum_f * BrightMul;
    bright_b = prod_b[BrightShift +: ChanW];
    bright_f = prod_f[BrightShift +: ChanW];
    back_le  = (bright_b <= bright_f);
  end

  always_comb begin
    item_d.back = back_i;
    item_d.fore = fore_i;
    for (int i = 0; i < NumChan; i++) begin
      unique case (mode_i)
        MODE_NORMAL:   item_d.op[i] = OP_FORE;
        MODE_MULTIPLY: item_d.op[i] = OP_MUL;
        MODE_SCREEN:   item_d.op[i] = OP_SCREEN;
        MODE_OVERLAY:  item_d.op[i] = (fore_i[i] <= OverlaySplit) ? OP_MUL : OP_SCREEN;
        MODE_DARKEN:   item_d.op[i] = back_le ? OP_BACK : OP_FORE;
        MODE_LIGHTEN:  item_d.op[i] = back_le ? OP_FORE : OP_BACK;
        MODE_DIFF:     item_d.op[i] = OP_DIFF;
        MODE_ADD:      item_d.op[i] = OP_ADD;
        default:       item_d.op[i] = OP_FORE;
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (drain) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== hdl/rbam_fifo.sv =====
// ----------------------------------------------------------------------------
// rbam_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module rbam_fifo #(
  parameter int unsigned Depth = rbam_pkg::FifoDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  rbam_pkg::item_t      wr_item_i,
  input  logic                 rd_i,
  output rbam_pkg::item_t      rd_item_o,
  output rbam_pkg::fifo_stat_t stat_o
);
  import rbam_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign do_wr        = wr_i && !stat_o.full;
  assign do_rd        = rd_i && !stat_o.empty;
  assign rd_item_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_rd && !do_wr) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not drop on read");
  a_no_rd_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_i && stat_o.empty))
    else $error("read from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count out of range");
  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on write");
  a_ptr_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_o.empty || stat_o.full) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hdl/rbam_back.sv =====
// ----------------------------------------------------------------------------
// rbam_back
// Three-stage blend and mix pipeline ending in the result register.
// ----------------------------------------------------------------------------
module rbam_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rbam_pkg::WeightW-1:0]  weight_i,
  input  rbam_pkg::fifo_stat_t          stat_i,
  input  rbam_pkg::item_t               item_i,
  output logic                          rd_o,
  output logic                          empty,
  input  logic                          pop,
  output rbam_pkg::pixel_t              pix_o
);
  import rbam_pkg::*;

  logic                               a_valid_q, b_valid_q, c_valid_q;
  logic                               adv_a, adv_b, adv_c;
  ch_op_e [NumChan-1:0]               a_op_q;
  pixel_t                             a_back_q, a_fore_q;
  logic   [NumChan-1:0][15:0]         a_prod_q, a_prod_d;
  pixel_t                             b_blend_q, b_blend_d, b_back_q;
  pixel_t                             c_pix_q, c_pix_d;
  logic   [16:0]                      div_sum;
  logic   [ChanW-1:0]                 mul_v;
  logic   [ChanW:0]                   add_v;
  logic   [WeightW-1:0]               w_sat, w_inv;
  logic   [16:0]                      mix_v;

  assign adv_c = !c_valid_q || pop;
  assign adv_b = !b_valid_q || adv_c;
  assign adv_a = !a_valid_q || adv_b;
  assign rd_o  = adv_a && !stat_i.empty;

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      a_prod_d[i] = item_i.back[i] * item_i.fore[i];
    end
  end

  // divide by 255: floor(p/255) == (p + (p>>8) + 1) >> 8 for 16-bit p
  always_comb begin
    div_sum = '0;
    mul_v   = '0;
    add_v   = '0;
    for (int i = 0; i < NumChan; i++) begin
      div_sum = 17'(a_prod_q[i]) + 17'(a_prod_q[i][15:8]) + 17'd1;
      mul_v   = div_sum[15:8];
      add_v   = 9'(a_back_q[i]) + 9'(a_fore_q[i]);
      case (a_op_q[i])
        OP_FORE:   b_blend_d[i] = a_fore_q[i];
        OP_BACK:   b_blend_d[i] = a_back_q[i];
        OP_MUL:    b_blend_d[i] = mul_v;
        OP_SCREEN: b_blend_d[i] = 8'(add_v - 9'(mul_v));
        OP_DIFF:   b_blend_d[i] = (a_back_q[i] >= a_fore_q[i]) ?
                                  (a_back_q[i] - a_fore_q[i]) :
                                  (a_fore_q[i] - a_back_q[i]);
        OP_ADD:    b_blend_d[i] = add_v[ChanW] ? ChanMax : add_v[ChanW-1:0];
        default:   b_blend_d[i] = a_fore_q[i];
      endcase
    end
  end

  always_comb begin
    w_sat = (weight_i > Q8One) ? Q8One : weight_i;
    w_inv = Q8One - w_sat;
    mix_v = '0;
    for (int i = 0; i < NumChan; i++) begin
      mix_v      = 17'(w_sat * b_blend_q[i]) + 17'(w_inv * b_back_q[i]);
      c_pix_d[i] = mix_v[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_q <= !stat_i.empty;
      end
      if (adv_b) begin
        b_valid_q <= a_valid_q;
      end
      if (adv_c) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_o) begin
      a_op_q   <= item_i.op;
      a_back_q <= item_i.back;
      a_fore_q <= item_i.fore;
      a_prod_q <= a_prod_d;
    end
    if (adv_b && a_valid_q) begin
      b_blend_q <= b_blend_d;
      b_back_q  <= a_back_q;
    end
    if (adv_c && b_valid_q) begin
      c_pix_q <= c_pix_d;
    end
  end

  assign empty = !c_valid_q;
  assign pix_o = c_pix_q;

endmodule

// ===== hdl/rgb_blend_mode_alpha_mixer.sv =====
// ----------------------------------------------------------------------------
// rgb_blend_mode_alpha_mixer
// Blends a foreground RGB pixel onto a background pixel and mixes by weight.
// ----------------------------------------------------------------------------
// One pixel pair is taken every clock while full is low, and one composited
// pixel leaves every clock while pop is high; the per-channel multipliers are
// fully pipelined, so nothing in the path iterates. An item passes in order
// through the classifying front register, the queue, the product stage and
// the blend stage, after which it sits in the mix register that drives the
// result ports. The queue of FifoDepth entries lets the front keep taking
// pixels while the result side stalls, until the queue fills.
// Write blend_mode and mix_weight only while no pixel is in flight.
// ----------------------------------------------------------------------------
module rgb_blend_mode_alpha_mixer #(
  parameter int unsigned FifoDepth = rbam_pkg::FifoDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rbam_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rbam_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    back_red_i,
  input  logic [7:0]                    back_green_i,
  input  logic [7:0]                    back_blue_i,
  input  logic [7:0]                    fore_red_i,
  input  logic [7:0]                    fore_green_i,
  input  logic [7:0]                    fore_blue_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o
);
  import rbam_pkg::*;

  mode_e              mode_q;
  logic [WeightW-1:0] weight_q;
  pixel_t             back_pix, fore_pix, out_pix;
  item_t              fe_item, fifo_item;
  logic               fe_valid;
  logic               fifo_rd;
  fifo_stat_t         fifo_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NORMAL;
      weight_q <= Q8One;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q   <= mode_e'(cfg_data_i[ModeW-1:0]);
        CFG_WEIGHT: weight_q <= cfg_data_i[WeightW-1:0];
        default:    ;
      endcase
    end
  end

  assign back_pix[0] = back_red_i;
  assign back_pix[1] = back_green_i;
  assign back_pix[2] = back_blue_i;
  assign fore_pix[0] = fore_red_i;
  assign fore_pix[1] = fore_green_i;
  assign fore_pix[2] = fore_blue_i;

  rbam_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .push         (push),
    .full         (full),
    .back_i       (back_pix),
    .fore_i       (fore_pix),
    .fifo_full_i  (fifo_stat.full),
    .item_valid_o (fe_valid),
    .item_o       (fe_item)
  );

  rbam_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fe_valid),
    .wr_item_i (fe_item),
    .rd_i      (fifo_rd),
    .rd_item_o (fifo_item),
    .stat_o    (fifo_stat)
  );

  rbam_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .weight_i (weight_q),
    .stat_i   (fifo_stat),
    .item_i   (fifo_item),
    .rd_o     (fifo_rd),
    .empty    (empty),
    .pop      (pop),
    .pix_o    (out_pix)
  );

  assign out_red_o   = out_pix[0];
  assign out_green_o = out_pix[1];
  assign out_blue_o  = out_pix[2];

endmodule
